// ===== rtl/core/ptrd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrd_pkg
// Shared types and constants of the pen-tablet report decoder.
// ----------------------------------------------------------------------------
package ptrd_pkg;

  localparam int WordWidth         = 16;
  localparam int ProdWidth         = 2 * WordWidth;
  localparam int CoordWidthDefault = 16;
  localparam int CmdFifoDepth      = 2;
  localparam int NumKeys           = 4;

  localparam logic [7:0] MinReportLen  = 8'd10;
  localparam logic [7:0] KindMove      = 8'h03;
  localparam logic [7:0] KindKey       = 8'h0C;
  localparam logic [7:0] KindPenKey    = 8'h01;
  localparam logic [7:0] ContactStatus = 8'hA1;
  localparam logic [7:0] PenKeyToggle  = 8'h00;

  localparam logic [7:0] KeyBitFirst  = 8'h01;
  localparam logic [7:0] KeyBitSecond = 8'h02;
  localparam logic [7:0] KeyBitThird  = 8'h04;
  localparam logic [7:0] KeyBitFourth = 8'h08;

  localparam logic [2:0] SlotFirst  = 3'd0;
  localparam logic [2:0] SlotSecond = 3'd1;
  localparam logic [2:0] SlotThird  = 3'd2;
  localparam logic [2:0] SlotFourth = 3'd3;
  localparam logic [2:0] SlotNone   = 3'd4;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_MOVE    = 2'd1,
    EV_KEY     = 2'd2,
    EV_PEN_KEY = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_90   = 2'd1,
    ROT_180  = 2'd2,
    ROT_270  = 2'd3
  } rotation_t;

  typedef enum logic [2:0] {
    CFG_ROTATION        = 3'd0,
    CFG_X_MAXIMUM       = 3'd1,
    CFG_Y_MAXIMUM       = 3'd2,
    CFG_KEY_CODE_FIRST  = 3'd3,
    CFG_KEY_CODE_SECOND = 3'd4,
    CFG_KEY_CODE_THIRD  = 3'd5,
    CFG_KEY_CODE_FOURTH = 3'd6
  } cfg_index_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_START,
    BK_DIV,
    BK_HOLD
  } back_state_t;

  typedef struct packed {
    logic [7:0]           report_length;
    logic [7:0]           report_kind;
    logic [7:0]           status_byte;
    logic [WordWidth-1:0] first_word;
    logic [WordWidth-1:0] second_word;
    logic [WordWidth-1:0] third_word;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic [1:0]           event_kind;
    logic                 changed_flag;
    logic                 down_flag;
    logic [WordWidth-1:0] out_x;
    logic [WordWidth-1:0] out_y;
    logic [WordWidth-1:0] out_pressure;
    logic [WordWidth-1:0] out_key_code;
  } out_item_t;

  typedef struct packed {
    rotation_t                          rotation;
    logic [WordWidth-1:0]               x_maximum;
    logic [WordWidth-1:0]               y_maximum;
    logic [NumKeys-1:0][WordWidth-1:0]  key_code;
  } cfg_regs_t;

  typedef struct packed {
    logic                 accepted;
    logic [1:0]           event_kind;
    logic                 changed_flag;
    logic                 down_flag;
    logic                 coord_valid;
    logic [WordWidth-1:0] x;
    logic [WordWidth-1:0] y;
    logic [WordWidth-1:0] pressure;
    logic [WordWidth-1:0] key_code;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_sts_t;

endpackage

// ===== rtl/core/pen_tablet_report_decoder_core.sv =====
// ----------------------------------------------------------------------------
// pen_tablet_report_decoder_core
// Decodes one pen-tablet report per transaction into one event transaction.
// The front end takes a report in the cycle it arrives unless the command
// queue is full, updates the pen, key and barrel-button state and queues a
// command in a two-entry queue. For a move or pen-key report the back end
// runs a pop, a 16x16 multiply, a divider start, 32 steps of the two
// bit-serial dividers that rotate x and y against the configured maxima and
// a check that they have finished, then the result register. Key and
// rejected reports take a pop and the result register. The back end pops
// a new command only after the result register has taken the last one.
// Configuration writes are taken every cycle and must only be issued while
// no report is in flight.
// ----------------------------------------------------------------------------
module pen_tablet_report_decoder_core #(
  parameter int COORD_WIDTH = ptrd_pkg::CoordWidthDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ptrd_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ptrd_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [ptrd_pkg::WordWidth-1:0] cfg_data
);
  import ptrd_pkg::*;

  cfg_regs_t cfg_r;
  fifo_ctl_t q_ctl;
  fifo_sts_t q_sts;
  cmd_t      push_cmd, head_cmd;
  logic      cmd_push, cmd_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotation  <= ROT_90;
      cfg_r.x_maximum <= WordWidth'(1);
      cfg_r.y_maximum <= WordWidth'(1);
      cfg_r.key_code  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROTATION:        cfg_r.rotation    <= rotation_t'(cfg_data[1:0]);
        CFG_X_MAXIMUM:       cfg_r.x_maximum   <= cfg_data;
        CFG_Y_MAXIMUM:       cfg_r.y_maximum   <= cfg_data;
        CFG_KEY_CODE_FIRST:  cfg_r.key_code[0] <= cfg_data;
        CFG_KEY_CODE_SECOND: cfg_r.key_code[1] <= cfg_data;
        CFG_KEY_CODE_THIRD:  cfg_r.key_code[2] <= cfg_data;
        CFG_KEY_CODE_FOURTH: cfg_r.key_code[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ptrd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_sts    (q_sts),
    .cmd_push (cmd_push),
    .cmd_data (push_cmd)
  );

  assign q_ctl.push = cmd_push;
  assign q_ctl.pop  = cmd_pop;

  ptrd_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (q_ctl),
    .wr_data (push_cmd),
    .rd_data (head_cmd),
    .sts     (q_sts)
  );

  ptrd_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_sts     (q_sts),
    .q_head    (head_cmd),
    .q_pop     (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |->
      out_data.event_kind == EV_NONE && !out_data.changed_flag && !out_data.down_flag &&
      out_data.out_x == '0 && out_data.out_y == '0 &&
      out_data.out_pressure == '0 && out_data.out_key_code == '0)
    else $error("rejected report carries nonzero fields");

  a_accept_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> out_data.event_kind != EV_NONE)
    else $error("accepted report without event kind");

  a_key_no_coord: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == EV_KEY |->
      out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_pressure == '0 &&
      out_data.changed_flag)
    else $error("key event carries coordinates or no change");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    q_sts.full |-> !in_ready)
    else $error("input taken while command queue full");
`endif

endmodule

// ===== rtl/core/ptrd_front.sv =====
// ----------------------------------------------------------------------------
// ptrd_front
// Accepts reports, classifies them, updates pen/key state, queues commands.
// ----------------------------------------------------------------------------
module ptrd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptrd_pkg::in_item_t  in_data,
  input  ptrd_pkg::cfg_regs_t cfg,
  input  ptrd_pkg::fifo_sts_t q_sts,
  output logic                cmd_push,
  output ptrd_pkg::cmd_t      cmd_data
);
  import ptrd_pkg::*;

  logic       pen_contact_r, pen_contact_nxt;
  logic       key_pressed_r, key_pressed_nxt;
  logic       barrel_r, barrel_nxt;
  logic [2:0] last_key_slot_r, last_key_slot_nxt;
  logic       len_ok;
  logic       contact_now;
  logic [7:0] key_bits;
  logic       xfer;

  assign in_ready = !q_sts.full;
  assign xfer     = in_valid && in_ready;
  assign cmd_push = xfer;

  assign len_ok      = in_data.report_length >= MinReportLen;
  assign contact_now = in_data.status_byte == ContactStatus;
  assign key_bits    = in_data.first_word[WordWidth-1:8];

  always_comb begin
    pen_contact_nxt   = pen_contact_r;
    key_pressed_nxt   = key_pressed_r;
    barrel_nxt        = barrel_r;
    last_key_slot_nxt = last_key_slot_r;
    cmd_data          = '0;
    priority if (len_ok && in_data.report_kind == KindMove) begin
      pen_contact_nxt       = contact_now;
      cmd_data.accepted     = 1'b1;
      cmd_data.event_kind   = EV_MOVE;
      cmd_data.changed_flag = contact_now != pen_contact_r;
      cmd_data.down_flag    = contact_now;
      cmd_data.coord_valid  = 1'b1;
      cmd_data.x            = in_data.first_word;
      cmd_data.y            = in_data.second_word;
      cmd_data.pressure     = in_data.third_word;
    end else if (len_ok && in_data.report_kind == KindKey) begin
      key_pressed_nxt = 1'b1;
      priority if (key_bits == KeyBitFirst) begin
        last_key_slot_nxt = SlotFirst;
      end else if (key_bits == KeyBitSecond) begin
        last_key_slot_nxt = SlotSecond;
      end else if (key_bits == KeyBitThird) begin
        last_key_slot_nxt = SlotThird;
      end else if (key_bits == KeyBitFourth) begin
        last_key_slot_nxt = SlotFourth;
      end else begin
        key_pressed_nxt = 1'b0;
        if (last_key_slot_r == SlotNone) begin
          last_key_slot_nxt = SlotFirst;
        end
      end
      cmd_data.accepted     = 1'b1;
      cmd_data.event_kind   = EV_KEY;
      cmd_data.changed_flag = 1'b1;
      cmd_data.down_flag    = key_pressed_nxt;
      cmd_data.key_code     = cfg.key_code[last_key_slot_nxt[1:0]];
    end else if (len_ok && in_data.report_kind == KindPenKey) begin
      cmd_data.accepted    = 1'b1;
      cmd_data.coord_valid = 1'b1;
      cmd_data.x           = in_data.first_word;
      cmd_data.y           = in_data.second_word;
      if (in_data.status_byte == PenKeyToggle) begin
        barrel_nxt            = !barrel_r;
        cmd_data.event_kind   = EV_PEN_KEY;
        cmd_data.changed_flag = 1'b1;
        cmd_data.down_flag    = !barrel_r;
      end else begin
        cmd_data.event_kind = EV_MOVE;
      end
    end else begin
      cmd_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_contact_r   <= 1'b0;
      key_pressed_r   <= 1'b0;
      barrel_r        <= 1'b0;
      last_key_slot_r <= SlotNone;
    end else if (xfer) begin
      pen_contact_r   <= pen_contact_nxt;
      key_pressed_r   <= key_pressed_nxt;
      barrel_r        <= barrel_nxt;
      last_key_slot_r <= last_key_slot_nxt;
    end
  end

endmodule

// ===== rtl/core/ptrd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// ptrd_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module ptrd_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  ptrd_pkg::fifo_ctl_t ctl,
  input  ptrd_pkg::cmd_t      wr_data,
  output ptrd_pkg::cmd_t      rd_data,
  output ptrd_pkg::fifo_sts_t sts
);
  import ptrd_pkg::*;

  localparam int PtrWidth = $clog2(CmdFifoDepth);
  localparam int CntWidth = $clog2(CmdFifoDepth + 1);

  cmd_t                entry_r [CmdFifoDepth];
  logic [PtrWidth-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntWidth-1:0] count_r;
  logic                do_push, do_pop;

  assign sts.full  = count_r == CntWidth'(CmdFifoDepth);
  assign sts.empty = count_r == '0;
  assign do_push   = ctl.push && !sts.full;
  assign do_pop    = ctl.pop && !sts.empty;
  assign rd_data   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrWidth'(CmdFifoDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrWidth'(CmdFifoDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/ptrd_divider.sv =====
// ----------------------------------------------------------------------------
// ptrd_divider
// Restoring divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module ptrd_divider #(
  parameter int COORD_WIDTH = ptrd_pkg::CoordWidthDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ptrd_pkg::ProdWidth-1:0] dividend,
  input  logic [ptrd_pkg::WordWidth-1:0] divisor,
  output logic                           done,
  output logic [COORD_WIDTH-1:0]         quotient
);
  import ptrd_pkg::*;

  localparam int CntWidth = $clog2(ProdWidth);
  localparam logic [ProdWidth-1:0] SatLimit =
    ProdWidth'((64'd1 << COORD_WIDTH) - 64'd1);

  logic                 busy_r, done_r;
  logic [CntWidth-1:0]  cnt_r;
  logic [WordWidth:0]   rem_r;
  logic [ProdWidth-1:0] quo_r;
  logic [WordWidth-1:0] dvs_r;
  logic [WordWidth:0]   rem_shift;
  logic                 fits;

  assign rem_shift = {rem_r[WordWidth-1:0], quo_r[ProdWidth-1]};
  assign fits      = rem_shift >= {1'b0, dvs_r};
  assign done      = done_r;
  assign quotient  = COORD_WIDTH'((quo_r > SatLimit) ? SatLimit : quo_r);

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? rem_shift - {1'b0, dvs_r} : rem_shift;
      quo_r <= {quo_r[ProdWidth-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CntWidth'(ProdWidth - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/ptrd_back.sv =====
// ----------------------------------------------------------------------------
// ptrd_back
// Executes queued commands: coordinate rotation and result register.
// ----------------------------------------------------------------------------
module ptrd_back #(
  parameter int COORD_WIDTH = ptrd_pkg::CoordWidthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptrd_pkg::cfg_regs_t cfg,
  input  ptrd_pkg::fifo_sts_t q_sts,
  input  ptrd_pkg::cmd_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ptrd_pkg::out_item_t out_data
);
  import ptrd_pkg::*;

  back_state_t          state_r, state_nxt;
  cmd_t                 cmd_r;
  logic [ProdWidth-1:0] prod_x_r, prod_y_r;
  logic [WordWidth-1:0] dvs_x_r, dvs_y_r;
  logic [WordWidth-1:0] ax, bx, dx, ay, by, dy;
  logic [WordWidth-1:0] xm, ym, sub_x, sub_y;
  logic                 mul_load, div_start, out_load, out_free;
  logic                 done_x, done_y;
  logic [COORD_WIDTH-1:0] q_x, q_y;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  assign xm    = (cfg.x_maximum == '0) ? WordWidth'(1) : cfg.x_maximum;
  assign ym    = (cfg.y_maximum == '0) ? WordWidth'(1) : cfg.y_maximum;
  assign sub_x = (xm > cmd_r.x) ? xm - cmd_r.x : '0;
  assign sub_y = (ym > cmd_r.y) ? ym - cmd_r.y : '0;

  always_comb begin
    ax = cmd_r.x;
    bx = WordWidth'(1);
    dx = WordWidth'(1);
    ay = cmd_r.y;
    by = WordWidth'(1);
    dy = WordWidth'(1);
    unique case (cfg.rotation)
      ROT_NONE: begin
      end
      ROT_90: begin
        ax = cmd_r.y;
        bx = xm;
        dx = ym;
        ay = sub_x;
        by = ym;
        dy = xm;
      end
      ROT_180: begin
        ax = sub_x;
        ay = sub_y;
      end
      ROT_270: begin
        ax = sub_y;
        bx = xm;
        dx = ym;
        ay = cmd_r.x;
        by = ym;
        dy = xm;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
    end
    if (mul_load) begin
      prod_x_r <= ProdWidth'(ax) * ProdWidth'(bx);
      prod_y_r <= ProdWidth'(ay) * ProdWidth'(by);
      dvs_x_r  <= dx;
      dvs_y_r  <= dy;
    end
  end

  ptrd_divider #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_x_r),
    .divisor  (dvs_x_r),
    .done     (done_x),
    .quotient (q_x)
  );

  ptrd_divider #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_y_r),
    .divisor  (dvs_y_r),
    .done     (done_y),
    .quotient (q_y)
  );

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_sts.empty) begin
          state_nxt = q_head.coord_valid ? BK_MUL : BK_HOLD;
        end
      end
      BK_MUL:   state_nxt = BK_START;
      BK_START: state_nxt = BK_DIV;
      BK_DIV: begin
        if (done_x && done_y) begin
          state_nxt = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mul_load  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      BK_IDLE:  q_pop = !q_sts.empty;
      BK_MUL:   mul_load = 1'b1;
      BK_START: div_start = 1'b1;
      BK_DIV: begin
      end
      BK_HOLD:  out_load = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.accepted     <= cmd_r.accepted;
      out_data_r.event_kind   <= cmd_r.event_kind;
      out_data_r.changed_flag <= cmd_r.changed_flag;
      out_data_r.down_flag    <= cmd_r.down_flag;
      out_data_r.out_x        <= cmd_r.coord_valid ? WordWidth'(q_x) : '0;
      out_data_r.out_y        <= cmd_r.coord_valid ? WordWidth'(q_y) : '0;
      out_data_r.out_pressure <= cmd_r.pressure;
      out_data_r.out_key_code <= cmd_r.key_code;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
